// ===== rtl/swos_pkg.sv =====
// Package for the sync word offset search block: widths, codes, stage types
// and the popcount and length helpers. Has no dependencies.
package swos_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned ERR_W      = 7;
  localparam int unsigned POS_HI_W   = OFFSET_W - 3;
  localparam int unsigned LANES      = 8;
  localparam int unsigned CAND_N     = 2 * LANES;
  localparam int unsigned CAND_IDX_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [LEN_W-1:0] SYNC_LEN_RESET = LEN_W'(4);
  localparam logic [LEN_W-1:0] SYNC_LEN_MAX   = LEN_W'(8);
  localparam logic [ERR_W-1:0] DIST_RESET     = ERR_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_WORD = 1'b0,
    REG_SYNC_LEN  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FIRST,
    OP_SEARCH
  } op_e;

  typedef logic [ERR_W-1:0] dist_t;

  // One request after the distance stage, handed to the selection stage.
  typedef struct packed {
    op_e                      op;
    logic                     last;
    logic                     too_short;
    logic [POS_HI_W-1:0]      pos_hi;
    dist_t                    full;
    dist_t [LANES-1:0]        lane_dist;
  } dist_req_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'b000, v[b]};
    end
    return n;
  endfunction

  function automatic dist_t popcount64(input logic [WORD_W-1:0] v);
    dist_t n;
    n = '0;
    for (int k = 0; k < WORD_W / 8; k++) begin
      n = n + {3'b000, popcount8(v[8*k +: 8])};
    end
    return n;
  endfunction

  // Length 0 counts as one byte, anything above eight as eight.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (l == '0) r = LEN_W'(1);
    else if (l > SYNC_LEN_MAX) r = SYNC_LEN_MAX;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] l);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      m[8*b +: 8] = (LEN_W'(b) < l) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/swos_if.sv =====
// Valid/ready channel interfaces for the packet bytes and the search result.
// Uses widths from swos_pkg.
interface swos_in_if;
  logic                       valid;
  logic                       ready;
  logic [swos_pkg::DATA_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface swos_out_if;
  logic                         valid;
  logic                         ready;
  logic [swos_pkg::OFFSET_W-1:0] sync_offset;
  logic                         polarity_inverted;
  logic [swos_pkg::ERR_W-1:0]    bit_errors;
  logic                         too_short;

  modport source (output valid, output sync_offset, output polarity_inverted,
                  output bit_errors, output too_short, input ready);
  modport sink   (input valid, input sync_offset, input polarity_inverted,
                  input bit_errors, input too_short, output ready);
endinterface

// ===== rtl/swos_dist.sv =====
// Distance stage: bit window and byte count, up to eight masked Hamming distances per
// byte, registered into a dist_req_t. Depends on swos_pkg.
module swos_dist #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [swos_pkg::DATA_W-1:0]       in_byte_i,
  input  logic                              in_last_i,
  input  logic [swos_pkg::WORD_W-1:0]       sync_word_i,
  input  logic [swos_pkg::LEN_W-1:0]        sync_len_i,
  input  logic                              take_i,
  output logic                              adv_o,
  output logic                              req_valid_o,
  output swos_pkg::dist_req_t               req_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

  logic [swos_pkg::WORD_W-1:0]                 win_q, win_d;
  logic [CNT_W-1:0]                            cnt_q, cnt_d;
  logic                                        req_valid_q;
  swos_pkg::dist_req_t                         req_q, req_d;

  logic [swos_pkg::LEN_W-1:0]                  len;
  logic [CNT_W-1:0]                            len_c;
  logic [swos_pkg::WORD_W-1:0]                 mask;
  logic [swos_pkg::WORD_W-1:0]                 word;
  logic [swos_pkg::WORD_W+swos_pkg::DATA_W-1:0] ext;
  logic [CNT_W-1:0]                            diff;
  logic [CNT_W+swos_pkg::POS_HI_W-1:0]         diff_ext;

  assign adv_o       = in_valid_i && (!req_valid_q || take_i);
  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  always_comb begin
    len      = swos_pkg::eff_len(sync_len_i);
    len_c    = CNT_W'(len);
    mask     = swos_pkg::len_mask(len);
    word     = sync_word_i & mask;
    ext      = {win_q, in_byte_i};
    diff     = cnt_q - len_c;
    diff_ext = {{swos_pkg::POS_HI_W{1'b0}}, diff};

    win_d         = win_q;
    cnt_d         = cnt_q;
    req_d         = '0;
    req_d.op      = swos_pkg::OP_NONE;
    req_d.last    = in_last_i;
    req_d.full    = swos_pkg::dist_t'({len, 3'b000});
    req_d.pos_hi  = diff_ext[swos_pkg::POS_HI_W-1:0];

    if (cnt_q < len_c) begin
      win_d = ext[swos_pkg::WORD_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_d == len_c) begin
        req_d.op           = swos_pkg::OP_FIRST;
        req_d.lane_dist[0] = swos_pkg::popcount64(
            word ^ (ext[swos_pkg::WORD_W-1:0] & mask));
      end
    end else if (cnt_q < CNT_MAX) begin
      // Offset j sees the window after j bits of the new byte have entered.
      req_d.op = swos_pkg::OP_SEARCH;
      for (int j = 0; j < swos_pkg::LANES; j++) begin
        req_d.lane_dist[j] = swos_pkg::popcount64(
            word ^ (ext[swos_pkg::WORD_W+swos_pkg::DATA_W-1-j -: swos_pkg::WORD_W] & mask));
      end
      win_d = ext[swos_pkg::WORD_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
    end

    req_d.too_short = (cnt_d < len_c);

    if (in_last_i) begin
      win_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      cnt_q       <= '0;
      req_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        win_q       <= win_d;
        cnt_q       <= cnt_d;
        req_valid_q <= 1'b1;
      end else if (take_i) begin
        req_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      req_q <= req_d;
    end
  end

endmodule

// ===== rtl/swos_best.sv =====
// Selection stage: picks the earliest smallest of sixteen candidate distances,
// tracks the best match and holds the result register. Depends on swos_pkg.
module swos_best (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  swos_pkg::dist_req_t           req_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [swos_pkg::OFFSET_W-1:0] sync_offset_o,
  output logic                          polarity_inverted_o,
  output logic [swos_pkg::ERR_W-1:0]    bit_errors_o,
  output logic                          too_short_o
);

  localparam int unsigned LEVELS = $clog2(swos_pkg::CAND_N);

  swos_pkg::dist_t                    best_d_q, best_d_d;
  logic [swos_pkg::OFFSET_W-1:0]      best_pos_q, best_pos_d;
  logic                               best_inv_q, best_inv_d;
  logic                               out_valid_q;
  logic [swos_pkg::OFFSET_W-1:0]      offset_q;
  logic                               inv_q;
  logic [swos_pkg::ERR_W-1:0]         err_q;
  logic                               short_q;

  swos_pkg::dist_t                    lv_val [LEVELS+1][swos_pkg::CAND_N];
  logic [swos_pkg::CAND_IDX_W-1:0]    lv_idx [LEVELS+1][swos_pkg::CAND_N];
  swos_pkg::dist_t                    min_val;
  logic [swos_pkg::CAND_IDX_W-1:0]    min_idx;
  logic                               out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign take_o   = req_valid_i && (!req_i.last || out_free);

  // Even candidates are the plain word, odd ones the inverted word; a right
  // operand wins only when strictly smaller, so the earliest test wins ties.
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int k = 0; k < swos_pkg::CAND_N; k++) begin
        lv_val[l][k] = '0;
        lv_idx[l][k] = '0;
      end
    end
    for (int j = 0; j < swos_pkg::LANES; j++) begin
      lv_val[0][2*j]   = req_i.lane_dist[j];
      lv_idx[0][2*j]   = swos_pkg::CAND_IDX_W'(2*j);
      lv_val[0][2*j+1] = req_i.full - req_i.lane_dist[j];
      lv_idx[0][2*j+1] = swos_pkg::CAND_IDX_W'(2*j+1);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < swos_pkg::CAND_N / 2; k++) begin
        if (k < (swos_pkg::CAND_N >> (l + 1))) begin
          if (lv_val[l][2*k+1] < lv_val[l][2*k]) begin
            lv_val[l+1][k] = lv_val[l][2*k+1];
            lv_idx[l+1][k] = lv_idx[l][2*k+1];
          end else begin
            lv_val[l+1][k] = lv_val[l][2*k];
            lv_idx[l+1][k] = lv_idx[l][2*k];
          end
        end
      end
    end
    min_val = lv_val[LEVELS][0];
    min_idx = lv_idx[LEVELS][0];
  end

  always_comb begin
    best_d_d   = best_d_q;
    best_pos_d = best_pos_q;
    best_inv_d = best_inv_q;
    case (req_i.op)
      swos_pkg::OP_FIRST: begin
        best_d_d   = req_i.lane_dist[0];
        best_pos_d = '0;
        best_inv_d = 1'b0;
      end
      swos_pkg::OP_SEARCH: begin
        if (min_val < best_d_q) begin
          best_d_d   = min_val;
          best_pos_d = {req_i.pos_hi, min_idx[swos_pkg::CAND_IDX_W-1:1]};
          best_inv_d = min_idx[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_d_q    <= swos_pkg::DIST_RESET;
      best_pos_q  <= '0;
      best_inv_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        if (req_i.last) begin
          best_d_q   <= swos_pkg::DIST_RESET;
          best_pos_q <= '0;
          best_inv_q <= 1'b0;
        end else begin
          best_d_q   <= best_d_d;
          best_pos_q <= best_pos_d;
          best_inv_q <= best_inv_d;
        end
      end
      if (take_o && req_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && req_i.last) begin
      if (req_i.too_short) begin
        offset_q <= '0;
        inv_q    <= 1'b0;
        err_q    <= '0;
        short_q  <= 1'b1;
      end else begin
        offset_q <= best_pos_d;
        inv_q    <= best_inv_d;
        err_q    <= best_d_d;
        short_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sync_offset_o       = offset_q;
  assign polarity_inverted_o = inv_q;
  assign bit_errors_o        = err_q;
  assign too_short_o         = short_q;

endmodule

// ===== rtl/sync_word_offset_search_top.sv =====
// Top level of the sync word offset search block: configuration registers,
// input register and the two processing stages. Depends on swos_pkg, swos_if,
// swos_dist and swos_best.
//
// Usage: packet bytes arrive on in_ch_i, one request per byte, MSB first in
// time, with last_byte set on the final byte. After the last byte one result
// leaves on out_ch_o: the bit offset of the best sync match, its polarity, the
// Hamming distance there, and too_short if the packet was shorter than the
// sync word. Bytes that are not last produce no result.
// Throughput is one byte per cycle while no last byte waits on a stalled
// result. Each byte passes an input register, the distance stage (eight
// 64-bit popcounts) and the selection stage (a sixteen-way minimum tree),
// which registers the result. Reset clears the search state and sets
// sync_word to 0 and sync_len to 4. While the receiver stalls a result, bytes
// that are not last keep flowing; a following last byte waits in the pipeline
// and the input fills after one more request. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
module sync_word_offset_search_top #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  swos_in_if.sink                           in_ch_i,
  swos_out_if.source                        out_ch_o,
  input  logic                              cfg_we_i,
  input  logic [swos_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [swos_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [swos_pkg::WORD_W-1:0] sync_word_q;
  logic [swos_pkg::LEN_W-1:0]  sync_len_q;
  logic                        s1_valid_q;
  logic [swos_pkg::DATA_W-1:0] s1_byte_q;
  logic                        s1_last_q;
  logic                        s1_adv;
  logic                        s2_take;
  logic                        s2_valid;
  swos_pkg::dist_req_t         s2_req;
  logic                        in_fire;

  assign in_ch_i.ready = !s1_valid_q || s1_adv;
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= '0;
      sync_len_q  <= swos_pkg::SYNC_LEN_RESET;
    end else if (cfg_we_i) begin
      case (swos_pkg::cfg_reg_e'(cfg_idx_i))
        swos_pkg::REG_SYNC_WORD: sync_word_q <= cfg_data_i[swos_pkg::WORD_W-1:0];
        swos_pkg::REG_SYNC_LEN:  sync_len_q  <= cfg_data_i[swos_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_ch_i.data_byte;
      s1_last_q <= in_ch_i.last_byte;
    end
  end

  swos_dist #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_byte_i   (s1_byte_q),
    .in_last_i   (s1_last_q),
    .sync_word_i (sync_word_q),
    .sync_len_i  (sync_len_q),
    .take_i      (s2_take),
    .adv_o       (s1_adv),
    .req_valid_o (s2_valid),
    .req_o       (s2_req)
  );

  swos_best u_best (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (s2_valid),
    .req_i               (s2_req),
    .take_o              (s2_take),
    .out_valid_o         (out_ch_o.valid),
    .out_ready_i         (out_ch_o.ready),
    .sync_offset_o       (out_ch_o.sync_offset),
    .polarity_inverted_o (out_ch_o.polarity_inverted),
    .bit_errors_o        (out_ch_o.bit_errors),
    .too_short_o         (out_ch_o.too_short)
  );

endmodule

// ===== rtl/swos_checker.sv =====
// Port-level checks for the sync word offset search block, bound to the top
// level. Depends on swos_pkg and sync_word_offset_search_top.
module swos_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swos_pkg::OFFSET_W-1:0] sync_offset,
  input logic                          polarity_inverted,
  input logic [swos_pkg::ERR_W-1:0]    bit_errors,
  input logic                          too_short
);

  // Last bytes accepted whose result has not yet been taken.
  logic [2:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b00, in_valid && in_ready && in_last}
                             - {2'b00, out_valid && out_ready};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(sync_offset) && $stable(polarity_inverted)
                                && $stable(bit_errors) && $stable(too_short))
    else $error("result payload changed while stalled");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && too_short |-> sync_offset == '0 && !polarity_inverted
                               && bit_errors == '0)
    else $error("short packet result carries match fields");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> bit_errors <= swos_pkg::DIST_RESET)
    else $error("bit error count above the word width");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 3'd0 && pending_q <= 3'd3)
    else $error("result without a matching last byte");

endmodule

bind sync_word_offset_search_top swos_checker u_swos_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_ch_i.valid),
  .in_ready          (in_ch_i.ready),
  .in_last           (in_ch_i.last_byte),
  .out_valid         (out_ch_o.valid),
  .out_ready         (out_ch_o.ready),
  .sync_offset       (out_ch_o.sync_offset),
  .polarity_inverted (out_ch_o.polarity_inverted),
  .bit_errors        (out_ch_o.bit_errors),
  .too_short         (out_ch_o.too_short)
);

// ===== test/sync_word_offset_search_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sync_word_offset_search_top: packets are sent byte by byte with
// random gaps and stalls, and each search result is checked against a local model.
// Depends on swos_pkg, swos_if and the block itself.
module sync_word_offset_search_top_tb;
  import swos_pkg::*;

  localparam int unsigned PKT_MAX_BYTES = 512;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned PHASES        = 10;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                inverted;
    logic [ERR_W-1:0]    errs;
    logic                short_pkt;
  } sync_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  swos_in_if  byte_ch ();
  swos_out_if res_ch ();

  sync_word_offset_search_top #(.MAX_PACKET_BYTES(PKT_MAX_BYTES)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (byte_ch),
    .out_ch_o   (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copies and search state of the local model.
  logic [WORD_W-1:0] sync_word_q = '0;
  logic [LEN_W-1:0]  sync_len_q  = SYNC_LEN_RESET;
  logic [WORD_W-1:0] win         = '0;
  int unsigned       n_seen      = 0;
  int unsigned       best_dist   = 64;
  int unsigned       best_pos    = 0;
  bit                best_inv    = 1'b0;

  pkt_byte_t    tx_bytes[$];
  sync_result_t pending_results[$];
  int           bytes_pending = 0;
  int unsigned  bytes_queued  = 0;
  int unsigned  mismatches    = 0;
  int unsigned  cycle_cnt     = 0;
  int unsigned  gap_left      = 0;
  int unsigned  stall_left    = 0;
  bit           byte_taken    = 1'b0;
  bit           idle_on       = 1'b1;
  int unsigned  phase_lens [PHASES] = '{1, 8, 0, 15, 2, 9, 3, 5, 7, 6};

  function automatic int unsigned live_len();
    if (sync_len_q == '0) return 1;
    if (sync_len_q > 4'd8) return 8;
    return 32'(sync_len_q);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the correlator by one byte and queues the result on a last byte.
  task automatic search_byte(input logic [DATA_W-1:0] b, input logic last);
    int unsigned       len;
    int unsigned       d;
    int unsigned       di;
    int unsigned       base;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] word;
    sync_result_t      r;
    len  = live_len();
    mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    word = sync_word_q & mask;
    if (n_seen < len) begin
      win = {win[WORD_W-9:0], b};
      n_seen++;
      if (n_seen == len) begin
        best_dist = $countones(word ^ (win & mask));
        best_pos  = 0;
        best_inv  = 1'b0;
      end
    end else if (n_seen < PKT_MAX_BYTES) begin
      base = 8 * (n_seen - len);
      for (int j = 0; j < 8; j++) begin
        d  = $countones(word ^ (win & mask));
        di = 8 * len - d;
        // Plain is tested first, so it wins a tie with inverted at one offset.
        if (d < best_dist) begin
          best_dist = d;
          best_pos  = base + j;
          best_inv  = 1'b0;
        end
        if (di < best_dist) begin
          best_dist = di;
          best_pos  = base + j;
          best_inv  = 1'b1;
        end
        win = {win[WORD_W-2:0], b[7-j]};
      end
      n_seen++;
    end
    if (last) begin
      if (n_seen < len) begin
        r = '0;
        r.short_pkt = 1'b1;
      end else begin
        r.offset    = OFFSET_W'(best_pos);
        r.inverted  = best_inv;
        r.errs      = ERR_W'(best_dist);
        r.short_pkt = 1'b0;
      end
      pending_results.push_back(r);
      win       = '0;
      n_seen    = 0;
      best_dist = 64;
      best_pos  = 0;
      best_inv  = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [DATA_W-1:0] b, input logic last);
    pkt_byte_t pb;
    pb.data = b;
    pb.last = last;
    tx_bytes.push_back(pb);
    bytes_pending++;
    bytes_queued++;
  endtask

  // Random packet, optionally with the sync word (or its inverse) placed at a
  // random bit offset at or after min_bit, then a few bits flipped anywhere.
  task automatic queue_packet(input int unsigned n_bytes, input bit embed,
                              input int unsigned min_bit, input bit invert,
                              input int unsigned n_flips);
    logic [7:0]        pkt [];
    int unsigned       len;
    int unsigned       at_bit;
    int unsigned       bitpos;
    logic [WORD_W-1:0] pattern;
    pkt = new[n_bytes];
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    len = live_len();
    if (embed && n_bytes >= len) begin
      pattern = invert ? ~sync_word_q : sync_word_q;
      at_bit  = $urandom_range(min_bit, 8 * (n_bytes - len));
      for (int k = 0; k < 8 * len; k++) begin
        bitpos = at_bit + k;
        pkt[bitpos / 8][7 - bitpos % 8] = pattern[8 * len - 1 - k];
      end
    end
    repeat (n_flips) begin
      bitpos = $urandom_range(0, 8 * n_bytes - 1);
      pkt[bitpos / 8][7 - bitpos % 8] = ~pkt[bitpos / 8][7 - bitpos % 8];
    end
    foreach (pkt[i]) push_byte(pkt[i], i == n_bytes - 1);
  endtask

  task automatic random_phase(input int unsigned n_items, input bit with_overlong);
    int unsigned len;
    int unsigned start;
    int unsigned r;
    len   = live_len();
    start = bytes_queued;
    // An exact match beyond the byte limit must be ignored.
    if (with_overlong)
      queue_packet(PKT_MAX_BYTES + $urandom_range(16, 24), 1'b1, 8 * (PKT_MAX_BYTES + 2),
                   $urandom_range(0, 1), 0);
    while (bytes_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65)
        queue_packet($urandom_range(len, len + 10), 1'b1, 0, $urandom_range(0, 1),
                     $urandom_range(0, 3));
      else if (r < 78)
        queue_packet($urandom_range(1, 16), 1'b0, 0, 1'b0, 0);
      else if (r < 92 && len > 1)
        queue_packet($urandom_range(1, len - 1), 1'b0, 0, 1'b0, 0);
      else
        queue_packet($urandom_range(24, 64), 1'b1, 0, $urandom_range(0, 1),
                     $urandom_range(0, 6));
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_SYNC_WORD) sync_word_q = val;
    else sync_len_q = val[LEN_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (bytes_pending != 0 || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Byte sender: a new request is presented once the previous one was taken.
  always @(negedge clk_i) begin : byte_driver
    pkt_byte_t nxt;
    if (rst_ni && (!byte_ch.valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (gap_left > 0 || tx_bytes.size() == 0) begin
        byte_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = tx_bytes.pop_front();
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= nxt.data;
        byte_ch.last_byte <= nxt.last;
        gap_left = idle_on ? pick_gap() : 0;
      end
    end
  end

  always @(negedge clk_i) begin : result_sink
    if (rst_ni) begin
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sync_result_t got;
    sync_result_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        if (byte_ch.valid && byte_ch.ready) begin
          search_byte(byte_ch.data_byte, byte_ch.last_byte);
          byte_taken = 1'b1;
          bytes_pending--;
        end
        if (res_ch.valid && res_ch.ready) begin
          got.offset    = res_ch.sync_offset;
          got.inverted  = res_ch.polarity_inverted;
          got.errs      = res_ch.bit_errors;
          got.short_pkt = res_ch.too_short;
          if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("unexpected result: offset %0d inv %0b errs %0d short %0b",
                       got.offset, got.inverted, got.errs, got.short_pkt);
          end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("mismatch: exp offset %0d inv %0b errs %0d short %0b, %s",
                         want.offset, want.inverted, want.errs, want.short_pkt,
                         $sformatf("got offset %0d inv %0b errs %0d short %0b",
                                   got.offset, got.inverted, got.errs, got.short_pkt));
            end
          end
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_SYNC_WORD;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    res_ch.ready      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: a zero word of four bytes.
    push_byte(8'hFF, 1'b1);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // All ones: plain distance 32 first, then the inverted word matches at offset 0.
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    repeat (2) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b1);
    wait_idle();

    // One-byte word: the first full window is tested against the plain word only.
    write_reg(REG_SYNC_WORD, 64'hFF);
    write_reg(REG_SYNC_LEN, 64'd1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) write_reg(REG_SYNC_WORD, '1);
      else if (ph == 2) write_reg(REG_SYNC_WORD, '0);
      else write_reg(REG_SYNC_WORD, {$urandom, $urandom});
      write_reg(REG_SYNC_LEN, CFG_DATA_W'(phase_lens[ph]));
      idle_on = (ph % 4 != 3);
      random_phase(130, ph == 4);
      wait_idle();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
